>>> hdl/tspl_pkg.sv
// Package for the tree softmax path loss core: codes, state types and constants.
// No dependencies; every other file of the block imports it.
package tspl_pkg;

  localparam int NUM_CLASSES_DEF = 1024;
  localparam int MAX_DEPTH_DEF   = 16;
  localparam int PROB_BITS_DEF   = 16;

  // Width of a stored log term, enough for the widest probability format.
  localparam int LT_W = 21;

  // ln(2) in Q2.58.
  localparam logic [63:0] LN2_Q = 64'h02C5C85FDF473DE7;

  localparam int FRAC_STEPS = 58;
  localparam int SERIES_TERMS = 30;

  localparam logic [1:0] FUNC_WR_PARENT = 2'd0;
  localparam logic [1:0] FUNC_WR_PROB   = 2'd1;
  localparam logic [1:0] FUNC_EVAL      = 2'd2;

  localparam logic [0:0] CFG_IGNORE_ENABLE = 1'd0;
  localparam logic [0:0] CFG_IGNORE_VALUE  = 1'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_DEPTH   = 2'd2;

  typedef enum logic [2:0] {
    L_IDLE, L_FDIV, L_MUL, L_MULRES, L_QDIV, L_FIN, L_RND
  } log_state_t;

  typedef enum logic [1:0] {
    T_IDLE, T_LOG, T_CHECK, T_READ
  } top_state_t;

endpackage

>>> hdl/tspl_log_unit.sv
// Iterative -ln(p) unit: one shared divider step and one 32x32 multiplier.
// Depends on tspl_pkg for constants and the sequencer state type.
module tspl_log_unit #(
  parameter int PROB_BITS = tspl_pkg::PROB_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [15:0]               code,
  output logic                      done,
  output logic [tspl_pkg::LT_W-1:0] term
);
  import tspl_pkg::*;

  localparam logic [15:0] PMASK =
    (PROB_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << PROB_BITS) - 32'd1);
  localparam logic [4:0] PB5 = 5'(PROB_BITS);
  localparam logic [63:0] RCP_ONES = '1;

  log_state_t state_r, state_nxt;

  logic [3:0]   e_r, e_nxt;
  logic [16:0]  den_r, den_nxt;
  logic [16:0]  rem_r, rem_nxt;
  logic [59:0]  quo_r, quo_nxt;
  logic [5:0]   it_r, it_nxt;
  logic [4:0]   k_r, k_nxt;
  logic [1:0]   mi_r, mi_nxt;
  logic         sq_r, sq_nxt;
  logic         dv_r, dv_nxt;
  logic [63:0]  a_r, a_nxt, b_r, b_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  zz_r, zz_nxt, tm_r, tm_nxt, sum_r, sum_nxt, r_r, r_nxt;

  logic [15:0]  p_m, p_c;
  logic [3:0]   e_c;
  logic [16:0]  num_c, den_c;
  logic [17:0]  dsr, tdiv, diff;
  logic         ge;
  logic [16:0]  rem_step;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  mres, quot, rnd, rcp;
  logic [68:0]  scaled;

  always_comb begin
    p_m = code & PMASK;
    p_c = (p_m == 16'd0) ? 16'd1 : p_m;
    e_c = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (p_c[i]) e_c = 4'(i);
    end
    num_c = {1'b0, p_c} - (17'd1 << e_c);
    den_c = {1'b0, p_c} + (17'd1 << e_c);
  end

  // Shared compare-subtract step of the fraction divide.
  always_comb begin
    dsr      = {1'b0, den_r};
    tdiv     = {rem_r, 1'b0};
    ge       = (tdiv >= dsr);
    diff     = tdiv - dsr;
    rem_step = ge ? diff[16:0] : tdiv[16:0];
  end

  // Reciprocal of 2k+1, rounded up to 64 fraction bits. For series terms below
  // 2^58 the top half of the product is the exact truncated quotient.
  always_comb begin
    case (k_r)
      5'd1:    rcp = RCP_ONES / 64'd3  + 64'd1;
      5'd2:    rcp = RCP_ONES / 64'd5  + 64'd1;
      5'd3:    rcp = RCP_ONES / 64'd7  + 64'd1;
      5'd4:    rcp = RCP_ONES / 64'd9  + 64'd1;
      5'd5:    rcp = RCP_ONES / 64'd11 + 64'd1;
      5'd6:    rcp = RCP_ONES / 64'd13 + 64'd1;
      5'd7:    rcp = RCP_ONES / 64'd15 + 64'd1;
      5'd8:    rcp = RCP_ONES / 64'd17 + 64'd1;
      5'd9:    rcp = RCP_ONES / 64'd19 + 64'd1;
      5'd10:   rcp = RCP_ONES / 64'd21 + 64'd1;
      5'd11:   rcp = RCP_ONES / 64'd23 + 64'd1;
      5'd12:   rcp = RCP_ONES / 64'd25 + 64'd1;
      5'd13:   rcp = RCP_ONES / 64'd27 + 64'd1;
      5'd14:   rcp = RCP_ONES / 64'd29 + 64'd1;
      5'd15:   rcp = RCP_ONES / 64'd31 + 64'd1;
      5'd16:   rcp = RCP_ONES / 64'd33 + 64'd1;
      5'd17:   rcp = RCP_ONES / 64'd35 + 64'd1;
      5'd18:   rcp = RCP_ONES / 64'd37 + 64'd1;
      5'd19:   rcp = RCP_ONES / 64'd39 + 64'd1;
      5'd20:   rcp = RCP_ONES / 64'd41 + 64'd1;
      5'd21:   rcp = RCP_ONES / 64'd43 + 64'd1;
      5'd22:   rcp = RCP_ONES / 64'd45 + 64'd1;
      5'd23:   rcp = RCP_ONES / 64'd47 + 64'd1;
      5'd24:   rcp = RCP_ONES / 64'd49 + 64'd1;
      5'd25:   rcp = RCP_ONES / 64'd51 + 64'd1;
      5'd26:   rcp = RCP_ONES / 64'd53 + 64'd1;
      5'd27:   rcp = RCP_ONES / 64'd55 + 64'd1;
      5'd28:   rcp = RCP_ONES / 64'd57 + 64'd1;
      5'd29:   rcp = RCP_ONES / 64'd59 + 64'd1;
      5'd30:   rcp = RCP_ONES / 64'd61 + 64'd1;
      default: rcp = '0;
    endcase
  end

  always_comb begin
    ah = mi_r[1] ? a_r[63:32] : a_r[31:0];
    bh = mi_r[0] ? b_r[63:32] : b_r[31:0];
    pp = ah * bh;
    case (mi_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    mres   = acc_r[121:58];
    quot   = acc_r[127:64];
    scaled = (PB5 - {1'b0, e_r}) * {5'd0, LN2_Q};
    rnd    = r_r + (64'd1 << 41);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE:   if (start) state_nxt = L_FDIV;
      L_FDIV:   if (it_r == 6'(FRAC_STEPS - 1)) state_nxt = L_MUL;
      L_MUL:    if (mi_r == 2'd3) state_nxt = dv_r ? L_QDIV : L_MULRES;
      L_MULRES: state_nxt = L_MUL;
      L_QDIV:   state_nxt = (k_r == 5'(SERIES_TERMS)) ? L_FIN : L_MUL;
      L_FIN:    state_nxt = L_RND;
      L_RND:    state_nxt = L_IDLE;
      default:  state_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    e_nxt = e_r; den_nxt = den_r; rem_nxt = rem_r; quo_nxt = quo_r;
    it_nxt = it_r; k_nxt = k_r; mi_nxt = mi_r; dv_nxt = dv_r;
    sq_nxt = sq_r; a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r;
    zz_nxt = zz_r; tm_nxt = tm_r; sum_nxt = sum_r; r_nxt = r_r;
    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          e_nxt   = e_c;
          den_nxt = den_c;
          rem_nxt = num_c;
          quo_nxt = '0;
          it_nxt  = '0;
        end
      end
      L_FDIV: begin
        rem_nxt = rem_step;
        quo_nxt = {quo_r[58:0], ge};
        it_nxt  = it_r + 6'd1;
        if (it_r == 6'(FRAC_STEPS - 1)) begin
          a_nxt   = {6'd0, quo_nxt[57:0]};
          b_nxt   = {6'd0, quo_nxt[57:0]};
          tm_nxt  = {6'd0, quo_nxt[57:0]};
          sum_nxt = {6'd0, quo_nxt[57:0]};
          sq_nxt  = 1'b1;
          dv_nxt  = 1'b0;
          acc_nxt = '0;
          mi_nxt  = '0;
        end
      end
      L_MUL: begin
        acc_nxt = acc_r + pp_sh;
        mi_nxt  = mi_r + 2'd1;
      end
      L_MULRES: begin
        if (sq_r) begin
          zz_nxt  = mres;
          sq_nxt  = 1'b0;
          k_nxt   = 5'd1;
          a_nxt   = tm_r;
          b_nxt   = mres;
        end else begin
          // The new odd power is divided by 2k+1 on the same multiplier.
          tm_nxt  = mres;
          a_nxt   = mres;
          b_nxt   = rcp;
          dv_nxt  = 1'b1;
        end
        acc_nxt = '0;
        mi_nxt  = '0;
      end
      L_QDIV: begin
        sum_nxt = sum_r + quot;
        dv_nxt  = 1'b0;
        k_nxt   = k_r + 5'd1;
        a_nxt   = tm_r;
        b_nxt   = zz_r;
        acc_nxt = '0;
        mi_nxt  = '0;
      end
      L_FIN: r_nxt = scaled[63:0] - {sum_r[62:0], 1'b0};
      L_RND: ;
      default: ;
    endcase
  end

  assign done = (state_r == L_RND);
  assign term = rnd[62:42];

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= L_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    e_r <= e_nxt; den_r <= den_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
    it_r <= it_nxt; k_r <= k_nxt; mi_r <= mi_nxt; dv_r <= dv_nxt;
    sq_r <= sq_nxt; a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt;
    zz_r <= zz_nxt; tm_r <= tm_nxt; sum_r <= sum_nxt; r_r <= r_nxt;
  end

endmodule

>>> hdl/tree_softmax_path_loss_core.sv
// Top level of the tree softmax path loss core: tables, walk sequencer, config.
// Depends on tspl_pkg and instantiates tspl_log_unit.
//
//  channel   ports                                       handshake
//  input     in_func in_class_index in_parent_index       start / busy
//            in_prob_code in_label
//  result    out_path_loss out_path_count out_status      out_valid (one cycle)
//  config    cfg_index cfg_wdata                          cfg_we
//
// A parent write is stored without raising busy. A probability write converts the
// code to its -ln term in the log unit and stores the term; busy stays high for
// 58 fraction divide steps, a square, 30 series terms (a multiply by z^2 and a
// multiply by the reciprocal of 2k+1, each followed by a step that takes the
// product), then scale and round.
// An evaluate request keeps busy high for a check and a registered table read
// per visited node and a final check, so at most MAX_DEPTH nodes are read.
// The result strobe comes in the cycle busy falls; an ignored label needs no
// busy cycle and its result comes in the next cycle.
// Reset is synchronous, active low, and clears control state only; the tables
// are not cleared. The receiver cannot stall: each result shows for one cycle.
module tree_softmax_path_loss_core #(
  parameter int NUM_CLASSES = tspl_pkg::NUM_CLASSES_DEF,
  parameter int MAX_DEPTH   = tspl_pkg::MAX_DEPTH_DEF,
  parameter int PROB_BITS   = tspl_pkg::PROB_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_func,
  input  logic [9:0]         in_class_index,
  input  logic signed [10:0] in_parent_index,
  input  logic [15:0]        in_prob_code,
  input  logic signed [10:0] in_label,
  output logic               out_valid,
  output logic [23:0]        out_path_loss,
  output logic [4:0]         out_path_count,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [10:0]        cfg_wdata
);
  import tspl_pkg::*;

  localparam int AW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);

  top_state_t state_r, state_nxt;

  logic               ign_en_r;
  logic [10:0]        ign_val_r;
  logic signed [10:0] node_r, node_nxt;
  logic [23:0]        loss_r, loss_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [AW-1:0]      waddr_r;
  logic               out_valid_r;
  logic [23:0]        out_loss_r;
  logic [4:0]         out_count_r;
  logic [1:0]         out_status_r;

  // Tables: the probability table holds the converted -ln term, not the code.
  logic [10:0]        parent_mem [NUM_CLASSES];
  logic [LT_W-1:0]    term_mem   [NUM_CLASSES];
  logic [10:0]        parent_rd_r;
  logic [LT_W-1:0]    term_rd_r;

  logic               accept, cls_ok, pwe, rd_en, ignored;
  logic [31:0]        cls_ext, node_ext, cnt_ext;
  logic [AW-1:0]      waddr_c, rd_addr;
  logic               node_in_range, depth_hit;
  logic [24:0]        lsum;
  logic               res_fire;
  logic [1:0]         res_status;
  logic               log_start, log_done;
  logic [LT_W-1:0]    log_term;

  tspl_log_unit #(.PROB_BITS(PROB_BITS)) u_log (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .code  (in_prob_code),
    .done  (log_done),
    .term  (log_term)
  );

  assign busy    = (state_r != T_IDLE);
  assign accept  = start && !busy;
  assign cls_ext = {22'd0, in_class_index};
  assign cls_ok  = (cls_ext < 32'(NUM_CLASSES));
  assign waddr_c = cls_ext[AW-1:0];
  assign ignored = ign_en_r && (in_label == $signed(ign_val_r));

  // A negative node or one past the table ends the walk like a root.
  assign node_ext      = {21'd0, node_r};
  assign node_in_range = !node_r[10] && (node_ext < 32'(NUM_CLASSES));
  assign rd_addr       = node_ext[AW-1:0];
  assign cnt_ext       = 32'(count_r);
  assign depth_hit     = (cnt_ext >= 32'(MAX_DEPTH));
  assign lsum          = {1'b0, loss_r} + 25'(term_rd_r);

  assign pwe       = accept && (in_func == FUNC_WR_PARENT) && cls_ok;
  assign log_start = accept && (in_func == FUNC_WR_PROB) && cls_ok;
  assign rd_en     = (state_r == T_CHECK) && node_in_range && !depth_hit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: begin
        if (log_start) state_nxt = T_LOG;
        else if (accept && (in_func == FUNC_EVAL) && !ignored) state_nxt = T_CHECK;
      end
      T_LOG:   if (log_done) state_nxt = T_IDLE;
      T_CHECK: state_nxt = rd_en ? T_READ : T_IDLE;
      T_READ:  state_nxt = T_CHECK;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    node_nxt   = node_r;
    loss_nxt   = loss_r;
    count_nxt  = count_r;
    res_fire   = 1'b0;
    res_status = ST_OK;
    unique case (state_r)
      T_IDLE: begin
        if (accept && (in_func == FUNC_EVAL)) begin
          node_nxt  = in_label;
          loss_nxt  = '0;
          count_nxt = '0;
          if (ignored) begin
            res_fire   = 1'b1;
            res_status = ST_IGNORED;
          end
        end
      end
      T_CHECK: begin
        if (!node_in_range) begin
          res_fire = 1'b1;
        end else if (depth_hit) begin
          res_fire   = 1'b1;
          res_status = ST_DEPTH;
        end
      end
      T_READ: begin
        loss_nxt  = lsum[24] ? 24'hFFFFFF : lsum[23:0];
        count_nxt = count_r + CNT_W'(1);
        node_nxt  = $signed(parent_rd_r);
      end
      T_LOG: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      ign_en_r    <= 1'b0;
      ign_val_r   <= 11'h7FF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_fire;
      if (cfg_we) begin
        case (cfg_index)
          CFG_IGNORE_ENABLE: ign_en_r  <= cfg_wdata[0];
          CFG_IGNORE_VALUE:  ign_val_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // An ignored label reports zero loss and count directly, because the walk
  // registers are only being cleared at that same edge.
  always_ff @(posedge clk) begin
    node_r  <= node_nxt;
    loss_r  <= loss_nxt;
    count_r <= count_nxt;
    if (log_start) waddr_r <= waddr_c;
    if (res_fire) begin
      out_loss_r   <= (res_status == ST_IGNORED) ? 24'd0 : loss_r;
      out_count_r  <= (res_status == ST_IGNORED) ? 5'd0 : cnt_ext[4:0];
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (pwe) parent_mem[waddr_c] <= in_parent_index;
    if (rd_en) parent_rd_r <= parent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if ((state_r == T_LOG) && log_done) term_mem[waddr_r] <= log_term;
    if (rd_en) term_rd_r <= term_mem[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_path_loss  = out_loss_r;
  assign out_path_count = out_count_r;
  assign out_status     = out_status_r;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the tree softmax path loss core: directed and random requests.
// Depends on tspl_pkg and tree_softmax_path_loss_core, and through it on tspl_log_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tspl_pkg::*;

  typedef enum logic [1:0] {K_REQ, K_CFG, K_PHASE, K_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t         kind;
    logic [1:0]         func;
    logic [9:0]         cls;
    logic signed [10:0] par;
    logic [15:0]        prob;
    logic signed [10:0] label;
    logic [0:0]         cfg_idx;
    logic [10:0]        cfg_val;
  } step_t;

  typedef struct {
    logic [23:0] loss;
    logic [4:0]  count;
    logic [1:0]  status;
  } loss_t;

  localparam int LIMIT_CYCLES = 3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = '0;
  logic [9:0] in_class_index = '0;
  logic signed [10:0] in_parent_index = '0;
  logic [15:0] in_prob_code = '0;
  logic signed [10:0] in_label = '0;
  logic out_valid;
  logic [23:0] out_path_loss;
  logic [4:0] out_path_count;
  logic [1:0] out_status;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [10:0] cfg_wdata = '0;

  tree_softmax_path_loss_core DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pending stimulus, in issue order, and the loss results still owed by the core.
  step_t pending_steps[$];
  loss_t owed_losses[$];

  // Predictor state: the core's tables and its ignore configuration.
  logic signed [10:0] pm_parent[NUM_CLASSES_DEF];
  logic [15:0]        pm_prob[NUM_CLASSES_DEF];
  logic               pm_ign_en = 1'b0;
  logic signed [10:0] pm_ign_val = -11'sd1;

  // Shadow used while building stimulus, so that no walk ever reads an entry
  // that was never written.
  logic signed [10:0] gen_parent[NUM_CLASSES_DEF];
  bit                 gen_par_ok[NUM_CLASSES_DEF];
  bit                 gen_prob_ok[NUM_CLASSES_DEF];
  logic               gen_ign_en = 1'b0;
  logic signed [10:0] gen_ign_val = -11'sd1;
  int                 tree_nodes[$];

  int mismatches = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int issued = 0;
  int accepted = 0;
  int hold_cycles = 0;
  bit stim_done = 0;

  // (a*b) >> 58 on Q2.58 operands.
  function automatic logic [63:0] q58_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] prod;
    prod = a * b;
    return prod[121:58];
  endfunction

  // -ln(p / 2^16) in Q8.16, through the atanh series of the mantissa ratio.
  function automatic logic [63:0] neg_ln_q16(logic [15:0] code);
    logic [63:0] p, num, den, rem, z, zz, term, acc, r;
    int top;
    p = {48'd0, code};
    if (p == 0) p = 1;
    top = 0;
    while ((p >> (top + 1)) != 0) top++;
    num = p - (64'd1 << top);
    den = p + (64'd1 << top);
    rem = num;
    z = 0;
    for (int i = 0; i < 58; i++) begin
      rem = rem << 1;
      z = z << 1;
      if (rem >= den) begin
        rem = rem - den;
        z[0] = 1'b1;
      end
    end
    zz = q58_mul(z, z);
    term = z;
    acc = z;
    for (int k = 1; k <= 30; k++) begin
      term = q58_mul(term, zz);
      acc = acc + term / (2 * k + 1);
    end
    r = 64'(16 - top) * LN2_Q - 2 * acc;
    return (r + (64'd1 << 41)) >> 42;
  endfunction

  function automatic loss_t walk_path(logic signed [10:0] label);
    loss_t res;
    int node;
    logic [63:0] sum;
    int cnt;
    sum = 0;
    cnt = 0;
    res.status = ST_OK;
    if (pm_ign_en && label == pm_ign_val) begin
      res.status = ST_IGNORED;
    end else begin
      node = label;
      while (node >= 0 && node < NUM_CLASSES_DEF) begin
        if (cnt >= MAX_DEPTH_DEF) begin
          res.status = ST_DEPTH;
          break;
        end
        sum = sum + neg_ln_q16(pm_prob[node]);
        if (sum > 64'hFFFFFF) sum = 64'hFFFFFF;
        cnt++;
        node = pm_parent[node];
      end
    end
    res.loss = sum[23:0];
    res.count = cnt[4:0];
    return res;
  endfunction

  // True when evaluating this label reads only entries already written.
  function automatic bit walk_is_defined(logic signed [10:0] label);
    int node;
    int cnt;
    if (gen_ign_en && label == gen_ign_val) return 1;
    node = label;
    cnt = 0;
    while (node >= 0) begin
      if (cnt >= MAX_DEPTH_DEF) return 1;
      if (!gen_par_ok[node] || !gen_prob_ok[node]) return 0;
      cnt++;
      node = gen_parent[node];
    end
    return 1;
  endfunction

  task automatic add_req(logic [1:0] func, int cls, int par, int prob, int label);
    step_t s;
    s = '{kind: K_REQ, func: func, cls: cls[9:0], par: par[10:0], prob: prob[15:0],
          label: label[10:0], cfg_idx: '0, cfg_val: '0};
    if (func == FUNC_WR_PARENT) begin
      gen_parent[s.cls] = s.par;
      gen_par_ok[s.cls] = 1;
    end else if (func == FUNC_WR_PROB) begin
      gen_prob_ok[s.cls] = 1;
    end
    pending_steps = {pending_steps, s};
  endtask

  task automatic add_ctl(step_kind_t kind, logic [0:0] idx, int val);
    step_t s;
    s = '{kind: kind, func: '0, cls: '0, par: '0, prob: '0, label: '0,
          cfg_idx: idx, cfg_val: val[10:0]};
    if (kind == K_CFG) begin
      if (idx == CFG_IGNORE_ENABLE) gen_ign_en = val[0];
      else gen_ign_val = val[10:0];
    end
    pending_steps = {pending_steps, s};
  endtask

  // Evaluate a label, falling back to a tree node or a negative label when the
  // requested walk would touch an unwritten entry.
  task automatic add_eval(int label);
    logic signed [10:0] lb;
    lb = label[10:0];
    if (!walk_is_defined(lb))
      lb = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
    if (!walk_is_defined(lb)) lb = -11'sd1 - $urandom_range(1023);
    add_req(FUNC_EVAL, 0, 0, 0, lb);
  endtask

  function automatic int rand_prob();
    case ($urandom_range(5))
      0: return $urandom_range(1);
      1: return 65535 - $urandom_range(1);
      2: return 1 << $urandom_range(15);
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic add_random(int n_items);
    int node;
    int pick;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      node = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
      if (pick < 10) begin
        // Parent rewrites keep the tree shape moving: roots, ring links, noise.
        if ($urandom_range(2) != 0)
          add_req(FUNC_WR_PARENT, node, $urandom_range(3) == 0 ? -1 - $urandom_range(1023)
                  : tree_nodes[$urandom_range(tree_nodes.size() - 1)], $urandom, $urandom);
        else
          add_req(FUNC_WR_PARENT, $urandom_range(1023), $urandom_range(2047) - 1024,
                  $urandom, $urandom);
      end else if (pick < 16) begin
        add_req(FUNC_WR_PROB, $urandom_range(1) ? node : $urandom_range(1023), $urandom,
                rand_prob(), $urandom);
      end else if (pick < 18) begin
        add_req(2'd3, $urandom_range(1023), $urandom, $urandom, $urandom);
      end else if (pick < 26) begin
        add_eval(gen_ign_val);
      end else if (pick < 36) begin
        add_eval($urandom_range(2047) - 1024);
      end else begin
        add_eval(node);
      end
    end
  endtask

  // Stimulus program: setup, directed checks, then three random phases.
  initial begin
    int n;
    foreach (gen_par_ok[i]) begin
      gen_par_ok[i] = 0;
      gen_prob_ok[i] = 0;
      gen_parent[i] = -11'sd1;
      pm_parent[i] = '0;
      pm_prob[i] = '0;
    end
    tree_nodes = {tree_nodes, 0};
    tree_nodes = {tree_nodes, 1023};
    while (tree_nodes.size() < 36) tree_nodes = {tree_nodes, int'($urandom_range(1, 1022))};

    add_ctl(K_CFG, CFG_IGNORE_ENABLE, 1);
    add_ctl(K_CFG, CFG_IGNORE_VALUE, -1);
    add_ctl(K_PHASE, 0, 27);
    // The first twenty nodes, all but node 1023, form one long chain, so walks from
    // its tail hit the depth limit. Node 1023 points at itself, a one-node cycle.
    n = tree_nodes.size();
    for (int i = 0; i < n; i++) begin
      if (i == 0) add_req(FUNC_WR_PARENT, tree_nodes[i], -1, 0, 0);
      else if (i == 1) add_req(FUNC_WR_PARENT, 1023, 1023, 0, 0);
      else if (i < 20) add_req(FUNC_WR_PARENT, tree_nodes[i], tree_nodes[i - 1], 0, 0);
      else add_req(FUNC_WR_PARENT, tree_nodes[i], $urandom_range(1) ? -1024
                   : tree_nodes[$urandom_range(i - 1)], 0, 0);
    end
    add_req(FUNC_WR_PARENT, tree_nodes[2], 0, 0, 0);
    for (int i = 0; i < n; i++)
      add_req(FUNC_WR_PROB, tree_nodes[i], 0,
              i == 0 ? 0 : i == 1 ? 65535 : i == 2 ? 1 : i == 3 ? 32768 : rand_prob(), 0);
    add_eval(tree_nodes[0]);
    add_eval(1023);
    add_eval(tree_nodes[19]);
    add_eval(tree_nodes[5]);
    add_eval(-1);
    add_eval(-1024);
    add_req(2'd3, 1023, 1023, 65535, 1023);
    add_eval(tree_nodes[0]);
    add_random(230);

    add_ctl(K_DRAIN, 0, 0);
    add_ctl(K_CFG, CFG_IGNORE_VALUE, -1024);
    add_ctl(K_PHASE, 0, 64);
    add_eval(-1024);
    add_eval(-1);
    add_random(110);
    add_ctl(K_DRAIN, 0, 0);
    add_random(110);

    add_ctl(K_DRAIN, 0, 0);
    add_ctl(K_CFG, CFG_IGNORE_ENABLE, 0);
    add_ctl(K_CFG, CFG_IGNORE_VALUE, -1 - $urandom_range(1023));
    add_ctl(K_PHASE, 0, 0);
    add_eval(gen_ign_val);
    add_random(230);
    stim_done = 1;

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    wait (stim_done && pending_steps.size() == 0 && accepted == issued);
    while (owed_losses.size() != 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && owed_losses.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Driver: a new step is taken from the queue once the previous request has
  // been accepted. A drain step waits for the core to go idle with nothing owed.
  always @(negedge clk) begin
    logic next_start;
    logic next_we;
    next_start = start;
    next_we = 1'b0;
    if (rst_n) begin
      if (start && accepted != issued) begin
        next_start = 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        next_start = 1'b0;
      end else begin
        next_start = 1'b0;
        if (pending_steps.size() != 0) begin
          case (pending_steps[0].kind)
            K_CFG: begin
              next_we = 1'b1;
              cfg_index <= pending_steps[0].cfg_idx;
              cfg_wdata <= pending_steps[0].cfg_val;
              void'(pending_steps.pop_front());
            end
            K_PHASE: begin
              idle_pct <= pending_steps[0].cfg_val;
              void'(pending_steps.pop_front());
            end
            K_DRAIN: begin
              // Writes cause no result, so the log unit may still be at work
              // here; busy going low marks the end of it.
              if (owed_losses.size() == 0 && !busy && accepted == issued) begin
                hold_cycles <= 40;
                void'(pending_steps.pop_front());
              end
            end
            default: begin
              if ($urandom_range(99) >= idle_pct) begin
                next_start = 1'b1;
                in_func <= pending_steps[0].func;
                in_class_index <= pending_steps[0].cls;
                in_parent_index <= pending_steps[0].par;
                in_prob_code <= pending_steps[0].prob;
                in_label <= pending_steps[0].label;
                issued <= issued + 1;
                void'(pending_steps.pop_front());
              end
            end
          endcase
        end
      end
    end
    start <= next_start;
    cfg_we <= next_we;
  end

  // Monitor: predicts at each accepted request and checks each result strobe
  // against the oldest owed loss.
  always @(posedge clk) begin
    loss_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_IGNORE_ENABLE) pm_ign_en = cfg_wdata[0];
        else pm_ign_val = cfg_wdata;
      end
      if (start && !busy) begin
        accepted <= accepted + 1;
        case (in_func)
          FUNC_WR_PARENT: pm_parent[in_class_index] = in_parent_index;
          FUNC_WR_PROB:   pm_prob[in_class_index] = in_prob_code;
          FUNC_EVAL:      owed_losses = {owed_losses, walk_path(in_label)};
          default: ;
        endcase
      end
      if (out_valid) begin
        if (owed_losses.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("ERROR: unexpected result loss=%0d count=%0d status=%0d",
                     out_path_loss, out_path_count, out_status);
        end else begin
          want = owed_losses.pop_front();
          if (want.loss !== out_path_loss || want.count !== out_path_count ||
              want.status !== out_status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("ERROR: expected loss=%0d count=%0d status=%0d, got %0d %0d %0d",
                       want.loss, want.count, want.status,
                       out_path_loss, out_path_count, out_status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
